### hdl/smve_pkg.sv
// ----------------------------------------------------------------------------
// smve_pkg: shared types and constants for the matrix-vector engine
// Request and result payloads, command codes, controller-datapath links.
// ----------------------------------------------------------------------------
package smve_pkg;

  localparam int DATA_W = 32;
  localparam int CMD_W  = 2;
  localparam int ROW_W  = 3;
  localparam int NUM_X  = 5;
  // 64-bit products, up to five summed, plus the rounding offset
  localparam int ACC_W  = 68;

  localparam logic [CMD_W-1:0] CMD_WRITE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_MULT  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_DIAG  = 2'd2;
  localparam logic [CMD_W-1:0] CMD_TRACE = 2'd3;

  localparam logic signed [DATA_W-1:0] SAT_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [DATA_W-1:0] SAT_MIN = 32'sh8000_0000;

  typedef struct packed {
    logic [CMD_W-1:0]         command;
    logic [ROW_W-1:0]         row;
    logic [ROW_W-1:0]         col;
    logic signed [DATA_W-1:0] value;
    logic signed [DATA_W-1:0] x0;
    logic signed [DATA_W-1:0] x1;
    logic signed [DATA_W-1:0] x2;
    logic signed [DATA_W-1:0] x3;
    logic signed [DATA_W-1:0] x4;
  } req_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] y0;
    logic signed [DATA_W-1:0] y1;
    logic signed [DATA_W-1:0] y2;
    logic signed [DATA_W-1:0] y3;
    logic signed [DATA_W-1:0] y4;
    logic                     saturated;
  } rsp_item_t;

  // Controller to datapath
  typedef struct packed {
    logic             wr_en;   // write the request's entry
    logic             start;   // capture operands, clear working results
    logic             issue;   // read one entry and send it down the pipe
    logic             first;   // first term of a sum
    logic             last;    // last term of a sum
    logic             trace;   // pass entry through, no rescale
    logic             scalar;  // multiply by the scalar, not a vector element
    logic [ROW_W-1:0] row;
    logic [ROW_W-1:0] col;
    logic [ROW_W-1:0] dest;    // result element that the sum lands in
    logic             push;    // move working results to the output register
  } ctl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic busy;      // terms still in the pipe
    logic out_free;  // output register can take a result this cycle
  } dp_status_t;

  // Tag that travels with each term through the datapath pipe
  typedef struct packed {
    logic             valid;
    logic             first;
    logic             last;
    logic             trace;
    logic [ROW_W-1:0] dest;
  } pipe_tag_t;

endpackage

### hdl/small_matrix_vector_engine.sv
// ----------------------------------------------------------------------------
// small_matrix_vector_engine: fixed-size matrix-vector multiply engine
// Holds a DIM x DIM fixed-point matrix; writes entries, multiplies by a
// vector, scales the diagonal and sums the trace.
// ----------------------------------------------------------------------------
// The block keeps a DIM x DIM matrix of signed fixed-point values with
// FRAC_BITS fraction bits (Q16.16 by default), all zero after reset. A write
// request (command 0) stores one entry and returns nothing; the block is
// ready again the next cycle, and a row or column outside the matrix drops
// the write. Multiply (command 1), scaled diagonal (command 2) and trace
// (command 3) each return one result transfer. One matrix entry flows
// through the single multiply-accumulate pipe per cycle while a request
// issues; a multiply reads min(DIM,5)^2 entries, the scaled diagonal
// min(DIM,5) and the trace DIM, and the pipe then drains before the result
// moves to the output register. The block works on one request at a time;
// stall stays high from the acceptance of a compute request until its
// result sits in the output register, and a finished result may wait there
// while the next request is taken. Products are exact, sums keep full
// width, then each element is rounded to nearest (ties up), rescaled and
// clipped to 32 bits, the trace only clipped; saturated reports any
// clipping among y0..y4. Vector elements past x4 count as zero, and
// result elements at or past DIM read as zero.
// ----------------------------------------------------------------------------
module small_matrix_vector_engine #(
  parameter int DIM       = 5,
  parameter int FRAC_BITS = 16
) (
  input  logic                clk,
  input  logic                rst,
  // request channel
  input  logic                req_valid,
  output logic                req_stall,
  input  smve_pkg::req_item_t req,
  // result channel
  output logic                rsp_valid,
  input  logic                rsp_stall,
  output smve_pkg::rsp_item_t rsp
);

  smve_pkg::ctl_cmd_t   cmd;
  smve_pkg::dp_status_t status;

  // Sequencer: decodes the request and walks the entries
  smve_ctrl #(
    .DIM (DIM)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .command   (req.command),
    .req_stall (req_stall),
    .status    (status),
    .cmd       (cmd)
  );

  // Matrix store, multiply-accumulate pipe and output register
  smve_datapath #(
    .DIM       (DIM),
    .FRAC_BITS (FRAC_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cmd       (cmd),
    .status    (status),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

endmodule

### hdl/smve_ctrl.sv
// ----------------------------------------------------------------------------
// smve_ctrl: command sequencer for the matrix-vector engine
// Accepts requests, walks the matrix entries a command needs, drains the
// datapath pipe and hands the result to the output register.
// ----------------------------------------------------------------------------
module smve_ctrl #(
  parameter int DIM = 5
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           req_valid,
  input  logic [smve_pkg::CMD_W-1:0]     command,
  output logic                           req_stall,
  input  smve_pkg::dp_status_t           status,
  output smve_pkg::ctl_cmd_t             cmd
);

  localparam int IDX_W = $clog2(DIM);
  localparam int NR    = (DIM < smve_pkg::NUM_X) ? DIM : smve_pkg::NUM_X;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_ISSUE = 2'd1;
  localparam logic [1:0] S_DRAIN = 2'd2;
  localparam logic [1:0] S_PUSH  = 2'd3;

  logic [1:0]                 state;
  logic [smve_pkg::CMD_W-1:0] op;
  logic [IDX_W-1:0]           i_cnt;
  logic [IDX_W-1:0]           j_cnt;

  logic accept;
  logic last_i;
  logic last_j;
  logic last_diag;
  logic issue_done;

  assign req_stall = (state != S_IDLE);
  assign accept    = req_valid && (state == S_IDLE);
  assign last_i    = (i_cnt == IDX_W'(NR - 1));
  assign last_j    = (j_cnt == IDX_W'(NR - 1));
  assign last_diag = (i_cnt == IDX_W'(DIM - 1));

  always_comb begin
    unique case (op)
      smve_pkg::CMD_MULT:  issue_done = last_i && last_j;
      smve_pkg::CMD_DIAG:  issue_done = last_i;
      smve_pkg::CMD_TRACE: issue_done = last_diag;
      default:             issue_done = 1'b1;
    endcase
  end

  always_comb begin
    cmd        = '0;
    cmd.wr_en  = accept && (command == smve_pkg::CMD_WRITE);
    cmd.start  = accept && (command != smve_pkg::CMD_WRITE);
    cmd.issue  = (state == S_ISSUE);
    cmd.trace  = (op == smve_pkg::CMD_TRACE);
    cmd.scalar = (op == smve_pkg::CMD_DIAG);
    cmd.row    = smve_pkg::ROW_W'(i_cnt);
    cmd.push   = (state == S_PUSH) && status.out_free;
    unique case (op)
      smve_pkg::CMD_MULT: begin
        cmd.col   = smve_pkg::ROW_W'(j_cnt);
        cmd.first = (j_cnt == '0);
        cmd.last  = last_j;
        cmd.dest  = smve_pkg::ROW_W'(i_cnt);
      end
      smve_pkg::CMD_TRACE: begin
        cmd.col   = smve_pkg::ROW_W'(i_cnt);
        cmd.first = (i_cnt == '0);
        cmd.last  = last_diag;
        cmd.dest  = '0;
      end
      default: begin
        cmd.col   = smve_pkg::ROW_W'(i_cnt);
        cmd.first = 1'b1;
        cmd.last  = 1'b1;
        cmd.dest  = smve_pkg::ROW_W'(i_cnt);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      op    <= smve_pkg::CMD_WRITE;
      i_cnt <= '0;
      j_cnt <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          i_cnt <= '0;
          j_cnt <= '0;
          if (accept && (command != smve_pkg::CMD_WRITE)) begin
            op    <= command;
            state <= S_ISSUE;
          end
        end
        S_ISSUE: begin
          // advance column first for the product, row only otherwise
          if (op == smve_pkg::CMD_MULT) begin
            if (last_j) begin
              j_cnt <= '0;
              i_cnt <= i_cnt + 1'b1;
            end else begin
              j_cnt <= j_cnt + 1'b1;
            end
          end else begin
            i_cnt <= i_cnt + 1'b1;
          end
          if (issue_done) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (!status.busy) begin
            state <= S_PUSH;
          end
        end
        S_PUSH: begin
          if (status.out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

### hdl/smve_datapath.sv
// ----------------------------------------------------------------------------
// smve_datapath: matrix store, multiply-accumulate pipe and result registers
// One entry read per issue; read, multiply, accumulate, then round and clip.
// ----------------------------------------------------------------------------
module smve_datapath #(
  parameter int DIM       = 5,
  parameter int FRAC_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  smve_pkg::req_item_t   req,
  input  smve_pkg::ctl_cmd_t    cmd,
  output smve_pkg::dp_status_t  status,
  output logic                  rsp_valid,
  input  logic                  rsp_stall,
  output smve_pkg::rsp_item_t   rsp
);

  localparam int DATA_W = smve_pkg::DATA_W;
  localparam int ACC_W  = smve_pkg::ACC_W;
  localparam int NUM_X  = smve_pkg::NUM_X;
  localparam int ROW_W  = smve_pkg::ROW_W;
  localparam int IDX_W  = $clog2(DIM);
  localparam int DEPTH  = DIM * DIM;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam logic [ROW_W:0] DIM_L = (ROW_W + 1)'(DIM);
  // half an output LSB, zero when there are no fraction bits
  localparam logic signed [ACC_W-1:0] ROUND = (ACC_W'(1) << FRAC_BITS) >> 1;

  // Matrix store
  logic signed [DATA_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]         written;
  logic [ADDR_W-1:0]        wr_addr;
  logic [ADDR_W-1:0]        rd_addr;
  logic                     wr_hit;

  // Captured operands
  logic signed [DATA_W-1:0] x_reg [NUM_X];
  logic signed [DATA_W-1:0] scalar_reg;

  // Pipe
  smve_pkg::pipe_tag_t        tag1, tag2, tag3;
  logic signed [DATA_W-1:0]   rd_data;
  logic                       rd_hit;
  logic signed [DATA_W-1:0]   op1;
  logic signed [DATA_W-1:0]   m1;
  logic signed [2*DATA_W-1:0] prod;
  logic signed [ACC_W-1:0]    acc;
  logic signed [ACC_W-1:0]    acc_base;
  logic signed [ACC_W-1:0]    scaled;
  logic                       fits;
  logic signed [DATA_W-1:0]   clipped;

  // Working results
  logic signed [DATA_W-1:0] y_work [NUM_X];
  logic                     sat_work;
  logic                     out_free;

  assign wr_hit  = ({1'b0, req.row} < DIM_L) && ({1'b0, req.col} < DIM_L);
  assign wr_addr = ADDR_W'(req.row[IDX_W-1:0]) * ADDR_W'(DIM)
                 + ADDR_W'(req.col[IDX_W-1:0]);
  assign rd_addr = ADDR_W'(cmd.row[IDX_W-1:0]) * ADDR_W'(DIM)
                 + ADDR_W'(cmd.col[IDX_W-1:0]);

  always_ff @(posedge clk) begin
    if (cmd.wr_en && wr_hit) begin
      mem[wr_addr] <= req.value;
    end
    if (cmd.issue) begin
      rd_data <= mem[rd_addr];
      rd_hit  <= written[rd_addr];
    end
  end

  // Entries never written read as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
    end else if (cmd.wr_en && wr_hit) begin
      written[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      x_reg[0]   <= req.x0;
      x_reg[1]   <= req.x1;
      x_reg[2]   <= req.x2;
      x_reg[3]   <= req.x3;
      x_reg[4]   <= req.x4;
      scalar_reg <= req.value;
    end
  end

  // Stage 1: entry read, operand select
  always_ff @(posedge clk) begin
    if (rst) begin
      tag1 <= '0;
    end else begin
      tag1.valid <= cmd.issue;
      tag1.first <= cmd.first;
      tag1.last  <= cmd.last;
      tag1.trace <= cmd.trace;
      tag1.dest  <= cmd.dest;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.issue) begin
      if (cmd.scalar) begin
        op1 <= scalar_reg;
      end else if (cmd.col < ROW_W'(NUM_X)) begin
        op1 <= x_reg[cmd.col];
      end else begin
        op1 <= '0;
      end
    end
  end

  assign m1 = rd_hit ? rd_data : '0;

  // Stage 2: product, or the entry itself for the trace
  always_ff @(posedge clk) begin
    if (rst) begin
      tag2 <= '0;
    end else begin
      tag2 <= tag1;
    end
  end

  always_ff @(posedge clk) begin
    if (tag1.valid) begin
      if (tag1.trace) begin
        prod <= {{DATA_W{m1[DATA_W-1]}}, m1};
      end else begin
        prod <= m1 * op1;
      end
    end
  end

  // Stage 3: accumulate; a sum starts at the rounding offset, a trace at zero
  assign acc_base = tag2.first ? (tag2.trace ? '0 : ROUND) : acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      tag3 <= '0;
    end else begin
      tag3 <= tag2;
    end
  end

  always_ff @(posedge clk) begin
    if (tag2.valid) begin
      acc <= acc_base + ACC_W'(prod);
    end
  end

  // Stage 4: rescale (not the trace), clip and store the finished element
  assign scaled  = tag3.trace ? acc : (acc >>> FRAC_BITS);
  assign fits    = (&scaled[ACC_W-1:DATA_W-1]) || !(|scaled[ACC_W-1:DATA_W-1]);
  assign clipped = fits ? scaled[DATA_W-1:0]
                 : (scaled[ACC_W-1] ? smve_pkg::SAT_MIN : smve_pkg::SAT_MAX);

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      for (int k = 0; k < NUM_X; k++) begin
        y_work[k] <= '0;
      end
      sat_work <= 1'b0;
    end else if (tag3.valid && tag3.last && (tag3.dest < ROW_W'(NUM_X))) begin
      y_work[tag3.dest] <= clipped;
      sat_work          <= sat_work || !fits;
    end
  end

  // Output register
  assign out_free = !rsp_valid || !rsp_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.push) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      rsp.y0        <= y_work[0];
      rsp.y1        <= y_work[1];
      rsp.y2        <= y_work[2];
      rsp.y3        <= y_work[3];
      rsp.y4        <= y_work[4];
      rsp.saturated <= sat_work;
    end
  end

  assign status.busy     = tag1.valid || tag2.valid || tag3.valid;
  assign status.out_free = out_free;

endmodule

### hdl/smve_checker.sv
// ----------------------------------------------------------------------------
// smve_checker: port-level checks for the matrix-vector engine
// Watches the request and result channels over time.
// ----------------------------------------------------------------------------
module smve_checker (
  input logic                clk,
  input logic                rst,
  input logic                req_valid,
  input logic                req_stall,
  input smve_pkg::req_item_t req,
  input logic                rsp_valid,
  input logic                rsp_stall,
  input smve_pkg::rsp_item_t rsp
);

  // A compute request occupies the block on the next cycle
  a_compute_holds: assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall && (req.command != smve_pkg::CMD_WRITE)) |=> req_stall)
    else $error("compute transfer did not occupy the block");

  // The block is ready again on the cycle after a write
  a_write_one_cycle: assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall && (req.command == smve_pkg::CMD_WRITE)) |=> !req_stall)
    else $error("block not ready after a write transfer");

  // A new result only comes out of a request in progress
  a_rsp_from_work: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(req_stall))
    else $error("result appeared with no request in progress");

  // Hold a stalled result
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp)))
    else $error("stalled result dropped or changed");

endmodule

bind small_matrix_vector_engine smve_checker u_smve_checker (.*);
